// ===== rtl/pwtm_pkg.sv =====
package pwtm_pkg;

  // Pedal sample width, unsigned fixed point
  localparam int SAMPLE_W = 16;

  // Channels handled side by side: throttle, brake
  localparam int LANES = 2;

  // Payload width of one beat on either stream
  localparam int DATA_W = SAMPLE_W * LANES;

  // Default window length
  localparam int WINDOW_LEN_DEF = 8;

  typedef logic [SAMPLE_W-1:0] sample_t;

endpackage

// ===== rtl/pedal_window_trimmed_mean_core.sv =====
// Pedal filter: every input beat shifts one throttle and one brake sample into
// per-channel windows of the last WINDOW_LEN samples (zero after reset). Each
// output beat gives, per channel, the common value when the whole window is
// equal, else the truncated mean of the samples strictly below the window
// maximum. One beat in gives exactly one beat out. The block works on one beat
// at a time: in_tready is low from the accepted input beat until the result is
// loaded into the output register, and comes back in that same cycle, when
// out_tvalid is set. The window is rotated past one compare/add unit per
// channel twice (a max/equality scan, then a below-max sum), followed by a
// bit-serial restoring divide, one quotient bit per cycle, and a done state
// that loads the output register once it is free. A finished result sits in
// the output register, so the next beat is accepted while it waits to be taken.
module pedal_window_trimmed_mean_core #(
  parameter int WINDOW_LEN = pwtm_pkg::WINDOW_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [pwtm_pkg::DATA_W-1:0] in_tdata,   // [15:0] throttle_sample, [31:16] brake_sample
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [pwtm_pkg::DATA_W-1:0] out_tdata   // [15:0] throttle_filtered, [31:16] brake_filtered
);

  localparam int SW       = pwtm_pkg::SAMPLE_W;
  localparam int NL       = pwtm_pkg::LANES;
  localparam int SUM_W    = SW + $clog2(WINDOW_LEN);
  localparam int CNT_W    = $clog2(WINDOW_LEN);
  localparam int STEP_MAX = (WINDOW_LEN > SUM_W) ? WINDOW_LEN : SUM_W;
  localparam int STEP_W   = $clog2(STEP_MAX);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_SUM  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [STEP_W-1:0]              step_r, step_nxt;
  pwtm_pkg::sample_t              win_r   [NL][WINDOW_LEN];
  pwtm_pkg::sample_t              win_nxt [NL][WINDOW_LEN];
  pwtm_pkg::sample_t              top_r   [NL];
  pwtm_pkg::sample_t              top_nxt [NL];
  pwtm_pkg::sample_t              ref_r   [NL];
  pwtm_pkg::sample_t              ref_nxt [NL];
  logic [NL-1:0]                  same_r, same_nxt;
  logic [SUM_W-1:0]               sum_r   [NL];
  logic [SUM_W-1:0]               sum_nxt [NL];
  logic [CNT_W-1:0]               cnt_r   [NL];
  logic [CNT_W-1:0]               cnt_nxt [NL];
  logic [SUM_W-1:0]               quo_r   [NL];
  logic [SUM_W-1:0]               quo_nxt [NL];
  logic [CNT_W-1:0]               rem_r   [NL];
  logic [CNT_W-1:0]               rem_nxt [NL];
  logic                           out_valid_r, out_valid_nxt;
  logic [pwtm_pkg::DATA_W-1:0]    out_data_r, out_data_nxt;

  pwtm_pkg::sample_t              tap     [NL];
  logic [SUM_W-1:0]               sum_add [NL];
  logic [CNT_W-1:0]               cnt_add [NL];
  logic [CNT_W:0]                 trial   [NL];
  logic                           fits    [NL];
  logic                           last_win;
  logic                           last_div;

  // Fixed read tap: the window rotates past it
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      tap[l]     = win_r[l][WINDOW_LEN-1];
      sum_add[l] = (tap[l] < top_r[l]) ? sum_r[l] + SUM_W'(tap[l]) : sum_r[l];
      cnt_add[l] = (tap[l] < top_r[l]) ? cnt_r[l] + CNT_W'(1) : cnt_r[l];
      trial[l]   = {rem_r[l], quo_r[l][SUM_W-1]};
      fits[l]    = trial[l] >= {1'b0, cnt_r[l]};
    end
  end

  assign last_win = (step_r == STEP_W'(WINDOW_LEN - 1));
  assign last_div = (step_r == STEP_W'(SUM_W - 1));

  // Sequencer and shared datapath
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    win_nxt       = win_r;
    top_nxt       = top_r;
    ref_nxt       = ref_r;
    same_nxt      = same_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          // shift new sample in at position 0
          for (int l = 0; l < NL; l++) begin
            win_nxt[l][0] = in_tdata[l*SW +: SW];
            for (int k = 1; k < WINDOW_LEN; k++) begin
              win_nxt[l][k] = win_r[l][k-1];
            end
          end
          step_nxt  = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // pass 1: window maximum and all-equal check
        for (int l = 0; l < NL; l++) begin
          win_nxt[l][0] = tap[l];
          for (int k = 1; k < WINDOW_LEN; k++) begin
            win_nxt[l][k] = win_r[l][k-1];
          end
          if (step_r == '0) begin
            top_nxt[l]  = tap[l];
            ref_nxt[l]  = tap[l];
            same_nxt[l] = 1'b1;
          end else begin
            if (tap[l] > top_r[l]) begin
              top_nxt[l] = tap[l];
            end
            if (tap[l] != ref_r[l]) begin
              same_nxt[l] = 1'b0;
            end
          end
          sum_nxt[l] = '0;
          cnt_nxt[l] = '0;
        end
        if (last_win) begin
          step_nxt  = '0;
          state_nxt = ST_SUM;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_SUM: begin
        // pass 2: sum and count of samples below the maximum
        for (int l = 0; l < NL; l++) begin
          win_nxt[l][0] = tap[l];
          for (int k = 1; k < WINDOW_LEN; k++) begin
            win_nxt[l][k] = win_r[l][k-1];
          end
          sum_nxt[l] = sum_add[l];
          cnt_nxt[l] = cnt_add[l];
          quo_nxt[l] = sum_add[l];
          rem_nxt[l] = '0;
        end
        if (last_win) begin
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_DIV: begin
        // restoring divide, one quotient bit per cycle
        for (int l = 0; l < NL; l++) begin
          rem_nxt[l] = fits[l] ? CNT_W'(trial[l] - {1'b0, cnt_r[l]}) : trial[l][CNT_W-1:0];
          quo_nxt[l] = {quo_r[l][SUM_W-2:0], fits[l]};
        end
        if (last_div) begin
          step_nxt  = '0;
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_DONE: begin
        // load output register once it is free
        if (!out_valid_r || out_tready) begin
          for (int l = 0; l < NL; l++) begin
            out_data_nxt[l*SW +: SW] = same_r[l] ? ref_r[l] : quo_r[l][SW-1:0];
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      for (int l = 0; l < NL; l++) begin
        for (int k = 0; k < WINDOW_LEN; k++) begin
          win_r[l][k] <= '0;
        end
      end
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      win_r       <= win_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    ref_r      <= ref_nxt;
    same_r     <= same_nxt;
    sum_r      <= sum_nxt;
    cnt_r      <= cnt_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
